// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the GPIO port.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge.
`define GPIO_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a trigger is followed by a consequence in the next cycle.
`define GPIO_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/gpio_pkg.sv =====
// Package for the eight-pin GPIO port: request and response types,
// request kinds, register offsets and identification words. No dependencies.
`default_nettype none

package gpio_pkg;

    localparam int NUM_PINS = 8;
    localparam int REG_W    = 8;
    localparam logic [REG_W-1:0] PIN_MASK = REG_W'((1 << NUM_PINS) - 1);

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_PIN   = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    localparam logic [11:0] OFF_DIR     = 12'h400;
    localparam logic [11:0] OFF_SENSE   = 12'h404;
    localparam logic [11:0] OFF_BOTH    = 12'h408;
    localparam logic [11:0] OFF_POL     = 12'h40C;
    localparam logic [11:0] OFF_IE      = 12'h410;
    localparam logic [11:0] OFF_RIS     = 12'h414;
    localparam logic [11:0] OFF_MIS     = 12'h418;
    localparam logic [11:0] OFF_ICR     = 12'h41C;
    localparam logic [11:0] OFF_AFSEL   = 12'h420;
    // The ID words occupy the top eight word slots of the window.
    localparam logic [6:0]  OFF_ID_HIGH = 7'h7F;

    localparam logic [7:0] ID_WORDS [8] = '{
        8'h61, 8'h10, 8'h04, 8'h00, 8'h0D, 8'hF0, 8'h05, 8'hB1
    };

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] bus_offset;
        logic [7:0]  write_data;
        logic [2:0]  pin_index;
        logic        pin_level;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] out_levels;
        logic       irq;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/gpio_port_with_edge_level_irq.sv =====
// Top level of the eight-pin GPIO port with edge and level interrupts.
// Depends on gpio_pkg and on the assertion macros in assert_macros.svh.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------
//   request | in        | req_valid, req_ready | req   (gpio_pkg::req_t)
//   result  | out       | rsp_valid, rsp_ready | rsp   (gpio_pkg::rsp_t)
//
// One request is taken per cycle while no held result stalls intake; its result sits
// in the output register from the next cycle on.
// The register file and all per-pin edge logic are evaluated in one pass.
// Reset clears every control and status register, marks all pins as inputs and empties the output.
// A held result stalls intake only while rsp_ready is low.
`default_nettype none
`include "assert_macros.svh"

module gpio_port_with_edge_level_irq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output      logic          req_ready,
    input  wire gpio_pkg::req_t req,
    output      logic          rsp_valid,
    input  wire logic          rsp_ready,
    output      gpio_pkg::rsp_t rsp
);
    import gpio_pkg::*;

    logic [REG_W-1:0] pin_data_reg, pin_data_next;
    logic [REG_W-1:0] direction_reg, direction_next;
    logic [REG_W-1:0] level_sense_reg, level_sense_next;
    logic [REG_W-1:0] both_edges_reg, both_edges_next;
    logic [REG_W-1:0] polarity_reg, polarity_next;
    logic [REG_W-1:0] raw_status_reg, raw_status_next;
    logic [REG_W-1:0] irq_enable_reg, irq_enable_next;
    logic [REG_W-1:0] alt_function_reg, alt_function_next;

    rsp_t rsp_reg, rsp_next;
    logic rsp_valid_reg;
    logic req_fire;

    logic [REG_W-1:0] wdata;
    logic [REG_W-1:0] addr_mask;
    logic [REG_W-1:0] pin_bit;
    logic [REG_W-1:0] raw_edge;
    logic [REG_W-1:0] lvl_pins;
    logic             data_region;
    logic             reg_written;
    logic             was_high;
    logic [REG_W-1:0] read_value;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign wdata       = req.write_data & PIN_MASK;
    assign addr_mask   = req.bus_offset[9:2];
    assign data_region = (req.bus_offset[11:10] == 2'b00);

    // Bus read decode.
    always_comb
    begin
        read_value = '0;
        if (data_region)
        begin
            read_value = pin_data_reg & addr_mask;
        end
        else if (req.bus_offset[11:5] == OFF_ID_HIGH && req.bus_offset[1:0] == 2'b00)
        begin
            read_value = ID_WORDS[req.bus_offset[4:2]];
        end
        else
        begin
            case (req.bus_offset)
                OFF_DIR:   read_value = direction_reg;
                OFF_SENSE: read_value = level_sense_reg;
                OFF_BOTH:  read_value = both_edges_reg;
                OFF_POL:   read_value = polarity_reg;
                OFF_IE:    read_value = irq_enable_reg;
                OFF_RIS:   read_value = raw_status_reg;
                OFF_MIS:   read_value = raw_status_reg & irq_enable_reg;
                OFF_AFSEL: read_value = alt_function_reg;
                default:   read_value = '0;
            endcase
        end
    end

    // Register writes and pin changes, then level re-evaluation.
    always_comb
    begin
        pin_data_next     = pin_data_reg;
        direction_next    = direction_reg;
        level_sense_next  = level_sense_reg;
        both_edges_next   = both_edges_reg;
        polarity_next     = polarity_reg;
        raw_edge          = raw_status_reg;
        irq_enable_next   = irq_enable_reg;
        alt_function_next = alt_function_reg;
        reg_written       = 1'b0;
        pin_bit           = '0;
        was_high          = 1'b0;

        case (kind_t'(req.kind))
            KIND_WRITE:
            begin
                reg_written = 1'b1;
                if (data_region)
                begin
                    pin_data_next = (pin_data_reg & ~(addr_mask & direction_reg))
                                  | (wdata & addr_mask & direction_reg);
                end
                else
                begin
                    case (req.bus_offset)
                        OFF_DIR:   direction_next    = wdata;
                        OFF_SENSE: level_sense_next  = wdata;
                        OFF_BOTH:  both_edges_next   = wdata;
                        OFF_POL:   polarity_next     = wdata;
                        OFF_IE:    irq_enable_next   = wdata;
                        OFF_ICR:   raw_edge          = raw_status_reg & ~wdata;
                        OFF_AFSEL: alt_function_next = wdata;
                        default:   reg_written       = 1'b0;
                    endcase
                end
            end
            KIND_PIN:
            begin
                reg_written = 1'b1;
                if (32'(req.pin_index) < NUM_PINS)
                begin
                    pin_bit = REG_W'(1) << req.pin_index;
                end
                // Output pins ignore external changes.
                pin_bit  = pin_bit & ~direction_reg;
                was_high = |(pin_data_reg & pin_bit);
                if (req.pin_level)
                begin
                    pin_data_next = pin_data_reg | pin_bit;
                end
                else
                begin
                    pin_data_next = pin_data_reg & ~pin_bit;
                end
                if (|(pin_bit & ~level_sense_reg) && was_high != req.pin_level)
                begin
                    if (|(pin_bit & both_edges_reg)
                        || (|(pin_bit & polarity_reg) ? req.pin_level : was_high))
                    begin
                        raw_edge = raw_status_reg | pin_bit;
                    end
                end
            end
            default:
            begin
                reg_written = 1'b0;
            end
        endcase

        lvl_pins = level_sense_next & ~direction_next & PIN_MASK;
        if (reg_written)
        begin
            raw_status_next = (raw_edge & ~lvl_pins)
                            | (~(pin_data_next ^ polarity_next) & lvl_pins);
        end
        else
        begin
            raw_status_next = raw_edge;
        end
    end

    always_comb
    begin
        rsp_next.read_data  = (kind_t'(req.kind) == KIND_READ) ? read_value : '0;
        rsp_next.out_levels = pin_data_next & direction_next;
        rsp_next.irq        = |(raw_status_next & irq_enable_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_data_reg     <= '0;
            direction_reg    <= '0;
            level_sense_reg  <= '0;
            both_edges_reg   <= '0;
            polarity_reg     <= '0;
            raw_status_reg   <= '0;
            irq_enable_reg   <= '0;
            alt_function_reg <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (req_fire)
            begin
                pin_data_reg     <= pin_data_next;
                direction_reg    <= direction_next;
                level_sense_reg  <= level_sense_next;
                both_edges_reg   <= both_edges_next;
                polarity_reg     <= polarity_next;
                raw_status_reg   <= raw_status_next;
                irq_enable_reg   <= irq_enable_next;
                alt_function_reg <= alt_function_next;
                rsp_valid_reg    <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // The held result always agrees with the state it was taken from.
    `GPIO_ASSERT_ALWAYS(a_levels_match, !rsp_valid_reg || rsp_reg.out_levels == (pin_data_reg & direction_reg), "out_levels disagrees with pin state")
    `GPIO_ASSERT_ALWAYS(a_irq_match, !rsp_valid_reg || rsp_reg.irq == (|(raw_status_reg & irq_enable_reg)), "irq disagrees with interrupt state")
    // Level-sensitive input pins always reflect their current match.
    `GPIO_ASSERT_ALWAYS(a_level_status, (raw_status_reg & level_sense_reg & ~direction_reg) == (~(pin_data_reg ^ polarity_reg) & level_sense_reg & ~direction_reg), "level status out of date")
    `GPIO_ASSERT_NEXT(a_read_no_change, req_fire && req.kind == KIND_READ, $stable(pin_data_reg) && $stable(raw_status_reg) && $stable(direction_reg), "bus read changed state")

endmodule

`default_nettype wire

// ===== test/tb_gpio_port_with_edge_level_irq.sv =====
// Testbench for the eight-pin GPIO port: directed and random requests are checked
// against a predictor of the port's registers, pins and interrupt logic.
// Depends on gpio_pkg and the gpio_port_with_edge_level_irq RTL.
`default_nettype none

module tb_gpio_port_with_edge_level_irq;
    import gpio_pkg::*;

    localparam logic [11:0] WRITE_OFFS [7] = '{
        OFF_DIR, OFF_SENSE, OFF_BOTH, OFF_POL, OFF_IE, OFF_ICR, OFF_AFSEL
    };
    localparam logic [11:0] READ_OFFS [9] = '{
        OFF_DIR, OFF_SENSE, OFF_BOTH, OFF_POL, OFF_IE, OFF_RIS, OFF_MIS, OFF_ICR, OFF_AFSEL
    };

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    req_t pending_req [$];
    rsp_t expected_rsp [$];
    rsp_t want_rsp;
    int   accepted_reqs = 0;
    int   error_count = 0;

    // Predicted register and pin state of the port.
    logic [7:0] port_pins  = '0;
    logic [7:0] port_dir   = '0;
    logic [7:0] port_sense = '0;
    logic [7:0] port_both  = '0;
    logic [7:0] port_pol   = '0;
    logic [7:0] port_ris   = '0;
    logic [7:0] port_ie    = '0;
    logic [7:0] port_afsel = '0;

    gpio_port_with_edge_level_irq u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Level-sensitive input pins follow the pin level against the polarity.
    function automatic void update_level_irqs();
        logic [7:0] lvl;
        lvl = port_sense & ~port_dir & PIN_MASK;
        port_ris = (port_ris & ~lvl) | (~(port_pins ^ port_pol) & lvl);
    endfunction

    function automatic void take_pin_change(logic [2:0] idx, logic lvl);
        logic [7:0] bit_m;
        logic       was_high;
        bit_m = 8'b1 << idx;
        if (int'(idx) >= NUM_PINS || (port_dir & bit_m) != 0)
            return;
        was_high = (port_pins & bit_m) != 0;
        if (lvl)
            port_pins = port_pins | bit_m;
        else
            port_pins = port_pins & ~bit_m;
        if ((port_sense & bit_m) == 0 && was_high != lvl)
        begin
            if ((port_both & bit_m) != 0 || ((port_pol & bit_m) != 0 ? lvl : was_high))
                port_ris = port_ris | bit_m;
        end
    endfunction

    function automatic logic [7:0] read_register(logic [11:0] off);
        if (off < OFF_DIR)
            return port_pins & off[9:2];
        if (off[11:5] == OFF_ID_HIGH && off[1:0] == 2'b00)
            return ID_WORDS[off[4:2]];
        case (off)
            OFF_DIR:   return port_dir;
            OFF_SENSE: return port_sense;
            OFF_BOTH:  return port_both;
            OFF_POL:   return port_pol;
            OFF_IE:    return port_ie;
            OFF_RIS:   return port_ris;
            OFF_MIS:   return port_ris & port_ie;
            OFF_AFSEL: return port_afsel;
            default:   return '0;
        endcase
    endfunction

    function automatic void write_register(logic [11:0] off, logic [7:0] data);
        logic [7:0] v;
        logic [7:0] m;
        v = data & PIN_MASK;
        if (off < OFF_DIR)
        begin
            // The address bits select which output pins the write may touch.
            m = off[9:2] & port_dir;
            port_pins = (port_pins & ~m) | (v & m);
        end
        else
        begin
            case (off)
                OFF_DIR:   port_dir   = v;
                OFF_SENSE: port_sense = v;
                OFF_BOTH:  port_both  = v;
                OFF_POL:   port_pol   = v;
                OFF_IE:    port_ie    = v;
                OFF_ICR:   port_ris   = port_ris & ~v;
                OFF_AFSEL: port_afsel = v;
                default:   return;
            endcase
        end
        update_level_irqs();
    endfunction

    function automatic rsp_t apply_request(req_t r);
        rsp_t res;
        res.read_data = '0;
        case (kind_t'(r.kind))
            KIND_READ:  res.read_data = read_register(r.bus_offset);
            KIND_WRITE: write_register(r.bus_offset, r.write_data);
            KIND_PIN:
            begin
                take_pin_change(r.pin_index, r.pin_level);
                update_level_irqs();
            end
            default: ;
        endcase
        res.out_levels = port_pins & port_dir;
        res.irq = |(port_ris & port_ie);
        return res;
    endfunction

    // Idling phases rotate every fifty requests: none, sender, receiver, both.
    function automatic int sender_idle_pct();
        case ((accepted_reqs / 50) % 4)
            1:       return 84;
            3:       return 28;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case ((accepted_reqs / 50) % 4)
            2:       return 84;
            3:       return 28;
            default: return 0;
        endcase
    endfunction

    task automatic queue_req(kind_t k, logic [11:0] off, logic [7:0] data,
                             logic [2:0] idx, logic lvl);
        req_t r;
        r.kind       = k;
        r.bus_offset = off;
        r.write_data = data;
        r.pin_index  = idx;
        r.pin_level  = lvl;
        pending_req.push_back(r);
    endtask

    // Request driver: the prediction is made at the edge that accepts the request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                expected_rsp.push_back(apply_request(req));
                accepted_reqs++;
            end
            if (!req_valid || req_ready)
            begin
                if (pending_req.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct())
                begin
                    req       <= pending_req.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $error("result arrived with no request outstanding");
                    error_count++;
                end
                else
                begin
                    want_rsp = expected_rsp.pop_front();
                    if (rsp.read_data !== want_rsp.read_data)
                    begin
                        $error("read_data: expected %0h, actual %0h",
                               want_rsp.read_data, rsp.read_data);
                        error_count++;
                    end
                    if (rsp.out_levels !== want_rsp.out_levels)
                    begin
                        $error("out_levels: expected %0h, actual %0h",
                               want_rsp.out_levels, rsp.out_levels);
                        error_count++;
                    end
                    if (rsp.irq !== want_rsp.irq)
                    begin
                        $error("irq: expected %0b, actual %0b", want_rsp.irq, rsp.irq);
                        error_count++;
                    end
                end
            end
            rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct());
        end
    end

    initial
    begin
        int pick;

        // Directed requests: ID words, masked data access, each interrupt sense.
        queue_req(KIND_READ,  12'hFE0, 8'h00, 3'd0, 1'b0);
        queue_req(KIND_READ,  12'hFFC, 8'hFF, 3'd7, 1'b1);
        queue_req(KIND_READ,  OFF_ICR, 8'h00, 3'd0, 1'b0);
        queue_req(KIND_WRITE, OFF_DIR, 8'h0F, 3'd0, 1'b0);
        queue_req(KIND_WRITE, 12'h3FC, 8'hFF, 3'd0, 1'b0);
        queue_req(KIND_WRITE, 12'h004, 8'h00, 3'd0, 1'b0);
        queue_req(KIND_READ,  12'h3FC, 8'h00, 3'd0, 1'b0);
        queue_req(KIND_READ,  12'h000, 8'h00, 3'd0, 1'b0);
        queue_req(KIND_WRITE, OFF_POL, 8'h30, 3'd0, 1'b0);
        queue_req(KIND_WRITE, OFF_IE,  8'hFF, 3'd0, 1'b0);
        queue_req(KIND_PIN,   12'h000, 8'h00, 3'd4, 1'b1);
        queue_req(KIND_PIN,   12'h000, 8'h00, 3'd6, 1'b1);
        queue_req(KIND_PIN,   12'h000, 8'h00, 3'd6, 1'b0);
        queue_req(KIND_WRITE, OFF_BOTH, 8'h80, 3'd0, 1'b0);
        queue_req(KIND_PIN,   12'h000, 8'h00, 3'd7, 1'b1);
        queue_req(KIND_READ,  OFF_RIS, 8'h00, 3'd0, 1'b0);
        queue_req(KIND_WRITE, OFF_ICR, 8'hFF, 3'd0, 1'b0);
        queue_req(KIND_WRITE, OFF_SENSE, 8'h20, 3'd0, 1'b0);
        queue_req(KIND_PIN,   12'h000, 8'h00, 3'd5, 1'b1);
        queue_req(KIND_READ,  OFF_MIS, 8'h00, 3'd0, 1'b0);
        // A change on an output pin is ignored.
        queue_req(KIND_PIN,   12'h000, 8'h00, 3'd0, 1'b1);
        queue_req(KIND_WRITE, OFF_AFSEL, 8'hA5, 3'd0, 1'b0);
        queue_req(KIND_READ,  OFF_AFSEL, 8'h00, 3'd0, 1'b0);
        // Offsets off a register's exact byte address, and the unused kind.
        queue_req(KIND_READ,  12'h401, 8'h00, 3'd0, 1'b0);
        queue_req(KIND_WRITE, 12'h40D, 8'hFF, 3'd0, 1'b0);
        queue_req(KIND_NONE,  12'hFFF, 8'hFF, 3'd7, 1'b1);

        // Random requests, mostly well-formed, with junk in the unused fields.
        for (int n = 0; n < 625; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 38)
                queue_req(KIND_PIN, 12'($urandom), 8'($urandom), 3'($urandom), 1'($urandom));
            else if (pick < 58)
                queue_req(KIND_WRITE, WRITE_OFFS[$urandom_range(0, 6)], 8'($urandom),
                          3'($urandom), 1'($urandom));
            else if (pick < 64)
                queue_req(KIND_WRITE, 12'($urandom_range(0, 1023)), 8'($urandom),
                          3'($urandom), 1'($urandom));
            else if (pick < 76)
                queue_req(KIND_READ, READ_OFFS[$urandom_range(0, 8)], 8'($urandom),
                          3'($urandom), 1'($urandom));
            else if (pick < 84)
                queue_req(KIND_READ, 12'($urandom_range(0, 1023)), 8'($urandom),
                          3'($urandom), 1'($urandom));
            else if (pick < 88)
                queue_req(KIND_READ, {OFF_ID_HIGH, 3'($urandom), 2'b00}, 8'($urandom),
                          3'($urandom), 1'($urandom));
            else if (pick < 96)
                queue_req($urandom_range(0, 1) ? KIND_WRITE : KIND_READ, 12'($urandom),
                          8'($urandom), 3'($urandom), 1'($urandom));
            else
                queue_req(KIND_NONE, 12'($urandom), 8'($urandom), 3'($urandom), 1'($urandom));
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Poll away from the active edge so the driver's updates have settled.
        @(negedge clk);
        while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
            @(negedge clk);
        repeat (5) @(posedge clk);

        if (error_count == 0)
            $display("gpio_port_with_edge_level_irq: match");
        else
            $display("gpio_port_with_edge_level_irq: mismatch");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("gpio_port_with_edge_level_irq: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
